// ===== src/esr_pkg.sv =====
// Shared types, widths and event codes for the edge scroll event remapper.
`timescale 1ns / 1ps

package esr_pkg;

   localparam int TYPE_W  = 5;
   localparam int CODE_W  = 10;
   localparam int VALUE_W = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [TYPE_W-1:0] EV_TYPE_KEY = 5'd1;
   localparam logic [TYPE_W-1:0] EV_TYPE_REL = 5'd2;
   localparam logic [TYPE_W-1:0] EV_TYPE_ABS = 5'd3;

   localparam logic [CODE_W-1:0] EV_CODE_TOUCH   = 10'h14A;
   localparam logic [CODE_W-1:0] EV_CODE_BUTTON0 = 10'h100;
   localparam logic [CODE_W-1:0] EV_CODE_REL_X   = 10'd0;
   localparam logic [CODE_W-1:0] EV_CODE_REL_Y   = 10'd1;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 16'sh8000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 16'sh7FFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POSITION_AXIS = 3'd0,
      CSR_MOVE_AXIS     = 3'd1,
      CSR_SCROLL_AXIS   = 3'd2,
      CSR_EDGE_LOW      = 3'd3,
      CSR_EDGE_HIGH     = 3'd4,
      CSR_INVERT        = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CODE_W-1:0]         position_axis_code;
      logic [CODE_W-1:0]         move_axis_code;
      logic [CODE_W-1:0]         scroll_axis_code;
      logic signed [VALUE_W-1:0] edge_low;
      logic signed [VALUE_W-1:0] edge_high;
      logic                      invert_scroll;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      position_axis_code: 10'd0,
      move_axis_code:     10'd1,
      scroll_axis_code:   10'd8,
      edge_low:           16'sd0,
      edge_high:          16'sh7FFF,
      invert_scroll:      1'b0
   };

endpackage

// ===== src/esr_channels.sv =====
// Valid/ready channel interfaces for events, results and register writes.
`timescale 1ns / 1ps

interface esr_event_if;
   import esr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [TYPE_W-1:0]         event_type;
   logic [CODE_W-1:0]         event_code;
   logic signed [VALUE_W-1:0] event_value;

   modport source (output valid, event_type, event_code, event_value, input ready);
   modport sink (input valid, event_type, event_code, event_value, output ready);
endinterface

interface esr_result_if;
   import esr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [TYPE_W-1:0]         out_type;
   logic [CODE_W-1:0]         out_code;
   logic signed [VALUE_W-1:0] out_value;
   logic                      stop_chain;

   modport source (output valid, out_type, out_code, out_value, stop_chain, input ready);
   modport sink (input valid, out_type, out_code, out_value, stop_chain, output ready);
endinterface

interface esr_csr_if;
   import esr_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/edge_scroll_event_remapper_top.sv =====
// Top level of the edge scroll event remapper.
`timescale 1ns / 1ps

// Rewrites touchpad input events so that a touch starting in an edge band
// turns relative motion into scroll events.
// Channels:
//   req_evt  - input events (type, code, value), valid/ready.
//   rsp_evt  - one result per event: type, code, value and stop flag.
//   csr_wr   - register writes (index, data); always ready, write only
//              while no event is in flight.
// The result is registered: it appears in the cycle after its event is taken.
// Throughput: one event per cycle; the single result register sets this,
// and an event is still taken in the cycle its predecessor's result leaves.
// When the receiver stalls, the result holds and the input stops taking
// events until the result register drains.
// Reset clears the touch latch, scroll mode and the result register and
// loads the register defaults.
module edge_scroll_event_remapper_top (
   input logic          clock,
   input logic          reset,
   esr_event_if.sink    req_evt,
   esr_result_if.source rsp_evt,
   esr_csr_if.sink      csr_wr
);
   import esr_pkg::*;

   cfg_type cfg;

   esr_csr_regs u_csr_regs (
      .clock (clock),
      .reset (reset),
      .csr   (csr_wr),
      .cfg   (cfg)
   );

   esr_remap_core u_remap_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req_evt),
      .rsp   (rsp_evt)
   );

endmodule

// ===== src/esr_csr_regs.sv =====
// Configuration register file written through the register write channel.
`timescale 1ns / 1ps

module esr_csr_regs (
   input  logic             clock,
   input  logic             reset,
   esr_csr_if.sink          csr,
   output esr_pkg::cfg_type cfg
);
   import esr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         case (csr.index)
            CSR_POSITION_AXIS: cfg_in.position_axis_code = csr.data[CODE_W-1:0];
            CSR_MOVE_AXIS:     cfg_in.move_axis_code     = csr.data[CODE_W-1:0];
            CSR_SCROLL_AXIS:   cfg_in.scroll_axis_code   = csr.data[CODE_W-1:0];
            CSR_EDGE_LOW:      cfg_in.edge_low           = $signed(csr.data[VALUE_W-1:0]);
            CSR_EDGE_HIGH:     cfg_in.edge_high          = $signed(csr.data[VALUE_W-1:0]);
            CSR_INVERT:        cfg_in.invert_scroll      = csr.data[0];
            default:           cfg_in = cfg_ff; // drop writes past the last register
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== src/esr_remap_core.sv =====
// Touch state tracking, event rewrite and the result register.
`timescale 1ns / 1ps

module esr_remap_core (
   input  logic             clock,
   input  logic             reset,
   input  esr_pkg::cfg_type cfg,
   esr_event_if.sink        req,
   esr_result_if.source     rsp
);
   import esr_pkg::*;

   logic signed [VALUE_W-1:0] touch_position_ff, touch_position_in;
   logic                      position_valid_ff, position_valid_in;
   logic                      scroll_active_ff, scroll_active_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [TYPE_W-1:0]         rsp_type_ff;
   logic [CODE_W-1:0]         rsp_code_ff, rsp_code_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in, value_neg;
   logic                      rsp_stop_ff, rsp_stop_in;

   logic fire;
   logic is_abs, is_touch, is_press, in_band;

   // take a new transaction whenever the result register is free or draining
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_type   = rsp_type_ff;
   assign rsp.out_code   = rsp_code_ff;
   assign rsp.out_value  = rsp_value_ff;
   assign rsp.stop_chain = rsp_stop_ff;

   assign is_abs   = (req.event_type == EV_TYPE_ABS);
   assign is_touch = (req.event_type == EV_TYPE_KEY) && (req.event_code == EV_CODE_TOUCH);
   assign is_press = (req.event_type == EV_TYPE_KEY) && (req.event_code == EV_CODE_BUTTON0)
                     && (req.event_value != '0);
   assign in_band  = position_valid_ff && (touch_position_ff >= cfg.edge_low)
                     && (touch_position_ff <= cfg.edge_high);
   // saturate the one value whose negation does not fit
   assign value_neg = (req.event_value == VALUE_MIN) ? VALUE_MAX : -req.event_value;

   always_comb begin
      touch_position_in = touch_position_ff;
      position_valid_in = position_valid_ff;
      scroll_active_in  = scroll_active_ff;
      rsp_code_in  = req.event_code;
      rsp_value_in = req.event_value;
      rsp_stop_in  = 1'b0;

      if (is_abs) begin
         if (req.event_code == cfg.position_axis_code) begin
            touch_position_in = req.event_value;
            position_valid_in = 1'b1;
         end
         rsp_value_in = '0;
         rsp_stop_in  = 1'b1;
      end else if (is_touch) begin
         if (req.event_value != '0) begin
            scroll_active_in = in_band;
         end else begin
            scroll_active_in  = 1'b0;
            position_valid_in = 1'b0;
         end
      end else if (scroll_active_ff && is_press) begin
         scroll_active_in = 1'b0;
      end else if (scroll_active_ff && (req.event_type == EV_TYPE_REL)) begin
         if (req.event_code == cfg.move_axis_code) begin
            rsp_code_in = cfg.scroll_axis_code;
            if (cfg.invert_scroll) begin
               rsp_value_in = value_neg;
            end
         end else if ((req.event_code == EV_CODE_REL_X) || (req.event_code == EV_CODE_REL_Y)) begin
            rsp_value_in = '0;
         end
      end

      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touch_position_ff <= '0;
         position_valid_ff <= 1'b0;
         scroll_active_ff  <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            touch_position_ff <= touch_position_in;
            position_valid_ff <= position_valid_in;
            scroll_active_ff  <= scroll_active_in;
         end
      end
   end

   // payload holds while the receiver stalls
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_type_ff  <= req.event_type;
         rsp_code_ff  <= rsp_code_in;
         rsp_value_ff <= rsp_value_in;
         rsp_stop_ff  <= rsp_stop_in;
      end
   end

endmodule

// ===== test/esr_remap_checker.sv =====
// Checker for the edge scroll event remapper: tracks state, predicts results, compares them.
`timescale 1ns / 1ps

module esr_remap_checker (
   input  logic  clock,
   input  logic  reset,
   esr_event_if  req_mon,
   esr_result_if rsp_mon,
   esr_csr_if    csr_mon,
   output int    mismatches,
   output int    outstanding,
   output int    results_seen
);
   import esr_pkg::*;

   typedef struct packed {
      logic [TYPE_W-1:0]  kind;
      logic [CODE_W-1:0]  code;
      logic [VALUE_W-1:0] value;
      logic               stop;
   } remapped_event_type;

   remapped_event_type        remapped_queue[$];
   cfg_type                   shadow_cfg = CFG_RESET;
   logic signed [VALUE_W-1:0] latched_position = '0;
   logic                      latch_valid = 1'b0;
   logic                      scrolling = 1'b0;
   int                        fail_total = 0;
   int                        checked = 0;

   function automatic remapped_event_type remap_event(logic [TYPE_W-1:0] ev_type,
                                                      logic [CODE_W-1:0] ev_code,
                                                      logic signed [VALUE_W-1:0] ev_value);
      remapped_event_type r;
      r.kind  = ev_type;
      r.code  = ev_code;
      r.value = ev_value;
      r.stop  = 1'b0;
      if (ev_type == EV_TYPE_ABS) begin
         if (ev_code == shadow_cfg.position_axis_code) begin
            latched_position = ev_value;
            latch_valid      = 1'b1;
         end
         r.value = '0;
         r.stop  = 1'b1;
      end else if (ev_type == EV_TYPE_KEY && ev_code == EV_CODE_TOUCH) begin
         if (ev_value != 0) begin
            scrolling = latch_valid
                        && $signed(latched_position) >= $signed(shadow_cfg.edge_low)
                        && $signed(latched_position) <= $signed(shadow_cfg.edge_high);
         end else begin
            scrolling   = 1'b0;
            latch_valid = 1'b0;
         end
      end else if (scrolling && ev_type == EV_TYPE_KEY && ev_code == EV_CODE_BUTTON0
                   && ev_value != 0) begin
         scrolling = 1'b0;
      end else if (scrolling && ev_type == EV_TYPE_REL) begin
         // move axis wins over the X/Y zeroing when the codes overlap
         if (ev_code == shadow_cfg.move_axis_code) begin
            r.code = shadow_cfg.scroll_axis_code;
            if (shadow_cfg.invert_scroll)
               r.value = (ev_value == VALUE_MIN) ? VALUE_MAX : -ev_value;
         end else if (ev_code == EV_CODE_REL_X || ev_code == EV_CODE_REL_Y) begin
            r.value = '0;
         end
      end
      return r;
   endfunction

   task automatic check_field(string field, int expected_v, int actual_v);
      if (expected_v != actual_v) begin
         fail_total++;
         $error("%s mismatch: expected %0d, actual %0d", field, expected_v, actual_v);
      end
   endtask

   always @(posedge clock) begin
      remapped_event_type want;
      if (reset) begin
         shadow_cfg       = CFG_RESET;
         latched_position = '0;
         latch_valid      = 1'b0;
         scrolling        = 1'b0;
         remapped_queue.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_POSITION_AXIS: shadow_cfg.position_axis_code = csr_mon.data[CODE_W-1:0];
               CSR_MOVE_AXIS:     shadow_cfg.move_axis_code     = csr_mon.data[CODE_W-1:0];
               CSR_SCROLL_AXIS:   shadow_cfg.scroll_axis_code   = csr_mon.data[CODE_W-1:0];
               CSR_EDGE_LOW:      shadow_cfg.edge_low           = csr_mon.data;
               CSR_EDGE_HIGH:     shadow_cfg.edge_high          = csr_mon.data;
               CSR_INVERT:        shadow_cfg.invert_scroll      = csr_mon.data[0];
               default: ;
            endcase
         end
         // compare before queuing: a result never leaves in the cycle its event enters
         if (rsp_mon.valid && rsp_mon.ready) begin
            checked++;
            if (remapped_queue.size() == 0) begin
               fail_total++;
               $error("result transaction with no event waiting: type %0d code %0d",
                      rsp_mon.out_type, rsp_mon.out_code);
            end else begin
               want = remapped_queue.pop_front();
               check_field("out_type", want.kind, rsp_mon.out_type);
               check_field("out_code", want.code, rsp_mon.out_code);
               check_field("out_value", $signed(want.value), rsp_mon.out_value);
               check_field("stop_chain", want.stop, rsp_mon.stop_chain);
            end
         end
         if (req_mon.valid && req_mon.ready)
            remapped_queue.push_back(remap_event(req_mon.event_type, req_mon.event_code,
                                                 req_mon.event_value));
      end
      mismatches   <= fail_total;
      outstanding  <= remapped_queue.size();
      results_seen <= checked;
   end

endmodule

// ===== test/edge_scroll_event_remapper_top_tb.sv =====
// Stimulus and verdict for the edge scroll event remapper: gestures, noise and register settings.
`timescale 1ns / 1ps

module edge_scroll_event_remapper_top_tb;
   import esr_pkg::*;

   localparam int RANDOM_PHASES    = 10;
   localparam int EVENTS_PER_PHASE = 145;

   localparam logic [TYPE_W-1:0]    EV_TYPE_NONE  = 5'd0;
   localparam logic [TYPE_W-1:0]    EV_TYPE_LAST  = 5'd31;
   localparam logic [CODE_W-1:0]    EV_CODE_OTHER = 10'd2;
   localparam logic [CODE_W-1:0]    EV_CODE_LAST  = 10'h3FF;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_HI = 3'd7;

   logic    clock = 1'b0;
   logic    reset;
   int      mismatches;
   int      outstanding;
   int      results_seen;
   int      sent_events = 0;
   int      settings_applied = 0;
   int      stall_left = 0;
   bit      steady_tail = 1'b0;
   cfg_type stim_cfg = CFG_RESET;

   esr_event_if  req_evt();
   esr_result_if rsp_evt();
   esr_csr_if    csr_wr();

   edge_scroll_event_remapper_top u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_evt(req_evt),
      .rsp_evt(rsp_evt),
      .csr_wr (csr_wr)
   );

   esr_remap_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_evt),
      .rsp_mon     (rsp_evt),
      .csr_mon     (csr_wr),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .results_seen(results_seen)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return '0;
         3: return VALUE_W'(int'($urandom_range(0, 20)) - 10);
         default: return VALUE_W'($urandom());
      endcase
   endfunction

   // favor positions inside the band so that touches turn scrolling on
   function automatic logic [VALUE_W-1:0] pick_position();
      int lo;
      int hi;
      lo = $signed(stim_cfg.edge_low);
      hi = $signed(stim_cfg.edge_high);
      if (lo <= hi && $urandom_range(0, 9) < 7)
         return VALUE_W'(lo + int'($urandom_range(0, hi - lo)));
      return rand_value();
   endfunction

   function automatic logic [CODE_W-1:0] pick_code();
      case ($urandom_range(0, 4))
         0: return EV_CODE_REL_X;
         1: return EV_CODE_REL_Y;
         2: return EV_CODE_LAST;
         default: return CODE_W'($urandom());
      endcase
   endfunction

   function automatic cfg_type random_settings();
      cfg_type c;
      int a;
      int b;
      a = $signed(rand_value());
      b = $signed(rand_value());
      c.position_axis_code = pick_code();
      c.move_axis_code     = pick_code();
      c.scroll_axis_code   = pick_code();
      c.invert_scroll      = 1'($urandom());
      case ($urandom_range(0, 5))
         0: begin
            // empty band, unless both picks are equal
            c.edge_low  = VALUE_W'((a > b) ? a : b);
            c.edge_high = VALUE_W'((a > b) ? b : a);
         end
         1: begin
            c.edge_low  = VALUE_MIN;
            c.edge_high = VALUE_MAX;
         end
         default: begin
            c.edge_low  = VALUE_W'((a < b) ? a : b);
            c.edge_high = VALUE_W'((a < b) ? b : a);
         end
      endcase
      return c;
   endfunction

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr.valid <= 1'b1;
      csr_wr.index <= idx;
      csr_wr.data  <= data;
      do @(posedge clock); while (!csr_wr.ready);
   endtask

   // upper data bits are random to show that the block drops them
   task automatic apply_settings(input cfg_type c);
      write_csr($urandom_range(0, 1) ? CSR_UNUSED_LO : CSR_UNUSED_HI, CSR_DATA_W'($urandom()));
      write_csr(CSR_POSITION_AXIS, {6'($urandom()), c.position_axis_code});
      write_csr(CSR_MOVE_AXIS, {6'($urandom()), c.move_axis_code});
      write_csr(CSR_SCROLL_AXIS, {6'($urandom()), c.scroll_axis_code});
      write_csr(CSR_EDGE_LOW, c.edge_low);
      write_csr(CSR_EDGE_HIGH, c.edge_high);
      write_csr(CSR_INVERT, {15'($urandom()), c.invert_scroll});
      csr_wr.valid <= 1'b0;
      stim_cfg = c;
      settings_applied++;
   endtask

   task automatic send_event(input logic [TYPE_W-1:0] ev_type,
                             input logic [CODE_W-1:0] ev_code,
                             input logic [VALUE_W-1:0] ev_value);
      if (!steady_tail && $urandom_range(0, 4) == 0) begin
         req_evt.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_evt.valid       <= 1'b1;
      req_evt.event_type  <= ev_type;
      req_evt.event_code  <= ev_code;
      req_evt.event_value <= ev_value;
      do @(posedge clock); while (!req_evt.ready);
      sent_events++;
   endtask

   // hold until every result is back, then let the pipeline settle
   task automatic wait_drained();
      req_evt.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic random_gesture();
      if ($urandom_range(0, 9) < 8)
         send_event(EV_TYPE_ABS, stim_cfg.position_axis_code, pick_position());
      else
         send_event(EV_TYPE_ABS, pick_code(), rand_value());
      send_event(EV_TYPE_KEY, EV_CODE_TOUCH,
                 $urandom_range(0, 1) ? VALUE_W'(1) : rand_value());
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: send_event(EV_TYPE_REL, stim_cfg.move_axis_code, rand_value());
            4: send_event(EV_TYPE_REL, EV_CODE_REL_X, rand_value());
            5: send_event(EV_TYPE_REL, EV_CODE_REL_Y, rand_value());
            6: send_event(EV_TYPE_REL, pick_code(), rand_value());
            7: send_event(EV_TYPE_KEY, EV_CODE_BUTTON0, VALUE_W'($urandom_range(0, 1)));
            8: send_event(EV_TYPE_ABS, pick_code(), rand_value());
            default: send_event(EV_TYPE_KEY, CODE_W'($urandom()), rand_value());
         endcase
      end
      if ($urandom_range(0, 9) < 8)
         send_event(EV_TYPE_KEY, EV_CODE_TOUCH, '0);
   endtask

   // stall the result side in short random bursts
   initial begin
      rsp_evt.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (!steady_tail && $urandom_range(0, 5) == 0) begin
            rsp_evt.ready <= 1'b0;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_evt.ready <= 1'b1;
         end
      end
   end

   initial begin
      reset               <= 1'b1;
      req_evt.valid       <= 1'b0;
      req_evt.event_type  <= '0;
      req_evt.event_code  <= '0;
      req_evt.event_value <= '0;
      csr_wr.valid        <= 1'b0;
      csr_wr.index        <= '0;
      csr_wr.data         <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // default settings: latch, scroll, button exit, release, unknown types
      send_event(EV_TYPE_ABS, CFG_RESET.position_axis_code, VALUE_W'(100));
      send_event(EV_TYPE_ABS, EV_CODE_OTHER, VALUE_MAX);
      send_event(EV_TYPE_KEY, EV_CODE_TOUCH, VALUE_W'(1));
      send_event(EV_TYPE_REL, EV_CODE_REL_Y, VALUE_W'(5));
      send_event(EV_TYPE_REL, EV_CODE_REL_X, VALUE_W'(-7));
      send_event(EV_TYPE_REL, EV_CODE_OTHER, VALUE_W'(3));
      send_event(EV_TYPE_KEY, EV_CODE_BUTTON0, '0);
      send_event(EV_TYPE_KEY, EV_CODE_BUTTON0, VALUE_W'(1));
      send_event(EV_TYPE_REL, EV_CODE_REL_Y, VALUE_W'(9));
      send_event(EV_TYPE_KEY, EV_CODE_TOUCH, '0);
      send_event(EV_TYPE_KEY, EV_CODE_TOUCH, VALUE_W'(1));
      send_event(EV_TYPE_REL, EV_CODE_REL_Y, VALUE_W'(4));
      send_event(EV_TYPE_LAST, EV_CODE_LAST, VALUE_MIN);
      send_event(EV_TYPE_NONE, EV_CODE_REL_X, '0);
      send_event(EV_TYPE_ABS, CFG_RESET.position_axis_code, VALUE_W'(-1));
      send_event(EV_TYPE_KEY, EV_CODE_TOUCH, VALUE_W'(1));
      wait_drained();

      // full band, move axis on rel X, inversion with saturation
      apply_settings('{position_axis_code: EV_CODE_LAST, move_axis_code: EV_CODE_REL_X,
                       scroll_axis_code: EV_CODE_LAST, edge_low: VALUE_MIN,
                       edge_high: VALUE_MAX, invert_scroll: 1'b1});
      send_event(EV_TYPE_ABS, EV_CODE_LAST, VALUE_MIN);
      send_event(EV_TYPE_KEY, EV_CODE_TOUCH, VALUE_MIN);
      send_event(EV_TYPE_REL, EV_CODE_REL_X, VALUE_MIN);
      send_event(EV_TYPE_REL, EV_CODE_REL_X, VALUE_MAX);
      send_event(EV_TYPE_REL, EV_CODE_REL_Y, VALUE_W'(4));
      send_event(EV_TYPE_KEY, EV_CODE_BUTTON0, VALUE_MAX);
      wait_drained();

      // empty band never turns scrolling on
      apply_settings('{position_axis_code: EV_CODE_REL_X, move_axis_code: EV_CODE_REL_Y,
                       scroll_axis_code: EV_CODE_REL_X, edge_low: VALUE_W'(10),
                       edge_high: VALUE_W'(5), invert_scroll: 1'b0});
      send_event(EV_TYPE_ABS, EV_CODE_REL_X, VALUE_W'(7));
      send_event(EV_TYPE_KEY, EV_CODE_TOUCH, VALUE_W'(1));
      send_event(EV_TYPE_REL, EV_CODE_REL_Y, VALUE_W'(3));

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         int target;
         target = sent_events + EVENTS_PER_PHASE;
         wait_drained();
         apply_settings(random_settings());
         if (phase == RANDOM_PHASES - 1)
            steady_tail = 1'b1;
         while (sent_events < target) begin
            if ($urandom_range(0, 9) < 8)
               random_gesture();
            else
               send_event(TYPE_W'($urandom()), CODE_W'($urandom()), VALUE_W'($urandom()));
         end
      end
      wait_drained();

      $display("Covered %0d events and %0d checked results over %0d register settings,",
               sent_events, results_seen, settings_applied + 1);
      $display("with gestures, noise, saturating inversion, empty bands and unused indexes.");
      if (mismatches == 0 && outstanding == 0)
         $display("edge_scroll_event_remapper_top verification clean");
      else
         $display("edge_scroll_event_remapper_top verification failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("edge_scroll_event_remapper_top verification failed");
      $finish;
   end

endmodule
